[hw/rtl/sexpr_tokenizer_top_defines.svh]
// Assertion macros used by the tokenizer emitter RTL
`ifndef SEXPR_TOKENIZER_TOP_DEFINES_SVH
`define SEXPR_TOKENIZER_TOP_DEFINES_SVH

// property checked on every clock, off while in reset
`define SEXPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define SEXPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/sexpr_tok_pkg.sv]
package sexpr_tok_pkg;

    typedef enum logic [2:0] {
        EV_OPEN       = 3'd0,
        EV_CLOSE      = 3'd1,
        EV_QUOTE      = 3'd2,
        EV_STR_BEGIN  = 3'd3,
        EV_ATOM_BEGIN = 3'd4,
        EV_CHAR       = 3'd5,
        EV_END        = 3'd6,
        EV_ESC_ERR    = 3'd7
    } ev_t;

    typedef enum logic [4:0] {
        MODE_BETWEEN = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_STRING  = 5'b00100,
        MODE_ESCAPE  = 5'b01000,
        MODE_ATOM    = 5'b10000
    } mode_t;

    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    // events caused by one byte, oldest in ev[0]
    typedef struct packed {
        ev_t [2:0]  ev;
        logic [7:0] ch;
        logic [1:0] cnt;
    } bundle_t;

endpackage

[hw/rtl/sexpr_tokenizer_top.sv]
// Channel  Dir  tdata           tuser          tlast
// s_*      in   [7:0] char_in   -              end_of_input
// m_*      out  [7:0] char_out  [2:0] event    last_of_run
//
// One byte can enter every cycle while each byte yields at most one beat; its
// beats start in the cycle after the byte is taken. A byte with several beats
// holds off the next byte until its last beat is taken, as the emitter holds a
// single result slot. Bytes with no beats only wait while the slot holds beats
// that are not on their final one with m_tready high. Reset clears the lexer
// mode to between tokens and empties the result slot. A stalled m_tready
// freezes the slot and keeps s_tready low for as long as the slot holds beats.
module sexpr_tokenizer_top
    import sexpr_tok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic [2:0] m_tuser,   // [2:0] event_res
    output logic       m_tlast
);

    bundle_t bundle;
    logic    accept;

    assign accept = s_tvalid && s_tready;

    sexpr_tok_lexer u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_in      (s_tdata),
        .end_of_input (s_tlast),
        .bundle       (bundle)
    );

    sexpr_tok_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .bundle   (bundle),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[hw/rtl/sexpr_tok_lexer.sv]
module sexpr_tok_lexer
    import sexpr_tok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_in,
    input  logic       end_of_input,
    output bundle_t    bundle
);

    mode_t   mode_reg;
    mode_t   mode_next;
    mode_t   b_mode;
    bundle_t bw;
    bundle_t nb;
    logic    blank;
    logic    delim;

    // byte handled between tokens
    always_comb
    begin
        blank  = char_in inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
        delim  = blank || char_in inside {CH_OPEN, CH_CLOSE, CH_QUOTE};
        bw     = '0;
        b_mode = MODE_BETWEEN;
        if (blank)
        begin
            b_mode = MODE_BETWEEN;
        end
        else if (char_in == CH_SEMI)
        begin
            b_mode = MODE_COMMENT;
        end
        else if (char_in == CH_OPEN)
        begin
            bw.ev[0] = EV_OPEN;
            bw.cnt   = 2'd1;
        end
        else if (char_in == CH_CLOSE)
        begin
            bw.ev[0] = EV_CLOSE;
            bw.cnt   = 2'd1;
        end
        else if (char_in == CH_QUOTE)
        begin
            bw.ev[0] = EV_QUOTE;
            bw.cnt   = 2'd1;
        end
        else if (char_in == CH_DQUOTE)
        begin
            bw.ev[0] = EV_STR_BEGIN;
            bw.cnt   = 2'd1;
            b_mode   = MODE_STRING;
        end
        else
        begin
            bw.ev[0] = EV_ATOM_BEGIN;
            bw.ev[1] = EV_CHAR;
            bw.ch    = char_in;
            bw.cnt   = 2'd2;
            b_mode   = MODE_ATOM;
        end
    end

    always_comb
    begin
        nb        = '0;
        mode_next = mode_reg;
        case (mode_reg)
            MODE_COMMENT:
            begin
                if (char_in == CH_LF)
                    mode_next = MODE_BETWEEN;
            end
            MODE_STRING:
            begin
                if (char_in == CH_BSLASH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else if (char_in == CH_DQUOTE)
                begin
                    nb.ev[0]  = EV_END;
                    nb.cnt    = 2'd1;
                    mode_next = MODE_BETWEEN;
                end
                else
                begin
                    nb.ev[0] = EV_CHAR;
                    nb.ch    = char_in;
                    nb.cnt   = 2'd1;
                end
            end
            MODE_ESCAPE:
            begin
                nb.ev[0] = EV_CHAR;
                nb.cnt   = 2'd1;
                if (char_in == CH_LOW_N)
                    nb.ch = CH_LF;
                else if (char_in == CH_LOW_T)
                    nb.ch = CH_TAB;
                else
                    nb.ch = char_in;
                mode_next = MODE_STRING;
            end
            MODE_ATOM:
            begin
                if (delim)
                begin
                    nb.ev[0]  = EV_END;
                    nb.ev[1]  = bw.ev[0];
                    nb.cnt    = 2'(2'd1 + bw.cnt);
                    mode_next = b_mode;
                end
                else
                begin
                    nb.ev[0] = EV_CHAR;
                    nb.ch    = char_in;
                    nb.cnt   = 2'd1;
                end
            end
            default:
            begin
                nb        = bw;
                mode_next = b_mode;
            end
        endcase

        // close whatever is open at end of text
        if (end_of_input)
        begin
            if (mode_next == MODE_ATOM || mode_next == MODE_STRING)
            begin
                nb.ev[nb.cnt] = EV_END;
                nb.cnt        = 2'(nb.cnt + 2'd1);
            end
            else if (mode_next == MODE_ESCAPE)
            begin
                nb.ev[nb.cnt] = EV_ESC_ERR;
                nb.cnt        = 2'(nb.cnt + 2'd1);
            end
            mode_next = MODE_BETWEEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_BETWEEN;
        else if (accept)
            mode_reg <= mode_next;
    end

    assign bundle = nb;

endmodule

[hw/rtl/sexpr_tok_emit.sv]
`include "sexpr_tokenizer_top_defines.svh"

module sexpr_tok_emit
    import sexpr_tok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  bundle_t    bundle,
    output logic       ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [2:0] m_tuser,
    output logic       m_tlast
);

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [1:0] cnt_reg;
    ev_t [2:0]  ev_reg;
    logic [7:0] ch_reg;
    logic       at_last;
    logic       load;
    ev_t        cur_ev;

    assign at_last = (idx_reg == 2'(cnt_reg - 2'd1));
    assign ready   = !valid_reg || (m_tready && at_last);
    assign load    = accept && (bundle.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
            cnt_reg   <= 2'd1;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
            cnt_reg   <= bundle.cnt;
        end
        else if (valid_reg && m_tready)
        begin
            if (at_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= 2'(idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg <= bundle.ev;
            ch_reg <= bundle.ch;
        end
    end

    assign cur_ev   = ev_reg[idx_reg];
    assign m_tvalid = valid_reg;
    assign m_tuser  = cur_ev;
    assign m_tdata  = (cur_ev == EV_CHAR) ? ch_reg : 8'd0;
    assign m_tlast  = at_last;

    `SEXPR_ASSERT(a_idx_in_range, valid_reg |-> (idx_reg < cnt_reg), "beat index past count")
    `SEXPR_ASSERT(a_load_when_free, load |-> (!valid_reg || (m_tready && at_last)), "load over live beats")
    `SEXPR_ASSERT_NEXT(a_drain, valid_reg && m_tready && at_last && !load, !valid_reg, "slot not drained")
    `SEXPR_ASSERT_NEXT(a_advance, valid_reg && m_tready && !at_last, valid_reg && (idx_reg == 2'($past(idx_reg) + 2'd1)), "beat index did not advance")

endmodule

[sim/tb_sexpr_tokenizer_top.sv]
module tb_sexpr_tokenizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sexpr_tok_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RANDOM_BYTES = 430;
    localparam logic [7:0] CH_UP_T = 8'h54;

    typedef struct {
        ev_t        ev;
        logic [7:0] ch;
        logic       last;
    } token_t;

    typedef logic [7:0] text_t[$];

    class token_scoreboard;
        mode_t  lex_mode;
        token_t expected_tokens[$];
        int     errors;

        function new();
            lex_mode = MODE_BETWEEN;
            errors = 0;
        endfunction

        static function logic is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF ||
                   c == CH_VT || c == CH_FF || c == CH_CR;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void push_token(ev_t ev, logic [7:0] ch);
            token_t t;
            t.ev = ev;
            t.ch = ch;
            t.last = 1'b0;
            expected_tokens = {expected_tokens, t};
        endfunction

        function void lex_between(logic [7:0] c);
            if (is_blank(c))
                lex_mode = MODE_BETWEEN;
            else if (c == CH_SEMI)
                lex_mode = MODE_COMMENT;
            else if (c == CH_OPEN)
            begin
                push_token(EV_OPEN, 8'h00);
                lex_mode = MODE_BETWEEN;
            end
            else if (c == CH_CLOSE)
            begin
                push_token(EV_CLOSE, 8'h00);
                lex_mode = MODE_BETWEEN;
            end
            else if (c == CH_QUOTE)
            begin
                push_token(EV_QUOTE, 8'h00);
                lex_mode = MODE_BETWEEN;
            end
            else if (c == CH_DQUOTE)
            begin
                push_token(EV_STR_BEGIN, 8'h00);
                lex_mode = MODE_STRING;
            end
            else
            begin
                push_token(EV_ATOM_BEGIN, 8'h00);
                push_token(EV_CHAR, c);
                lex_mode = MODE_ATOM;
            end
        endfunction

        // work out the tokens caused by one accepted source byte
        function void note_byte(logic [7:0] c, logic eoi);
            int n0;
            n0 = expected_tokens.size();
            case (lex_mode)
                MODE_COMMENT:
                begin
                    if (c == CH_LF)
                        lex_mode = MODE_BETWEEN;
                end
                MODE_STRING:
                begin
                    if (c == CH_BSLASH)
                        lex_mode = MODE_ESCAPE;
                    else if (c == CH_DQUOTE)
                    begin
                        push_token(EV_END, 8'h00);
                        lex_mode = MODE_BETWEEN;
                    end
                    else
                        push_token(EV_CHAR, c);
                end
                MODE_ESCAPE:
                begin
                    if (c == CH_LOW_N)
                        push_token(EV_CHAR, CH_LF);
                    else if (c == CH_LOW_T)
                        push_token(EV_CHAR, CH_TAB);
                    else
                        push_token(EV_CHAR, c);
                    lex_mode = MODE_STRING;
                end
                MODE_ATOM:
                begin
                    if (is_blank(c) || c == CH_OPEN || c == CH_CLOSE || c == CH_QUOTE)
                    begin
                        push_token(EV_END, 8'h00);
                        lex_between(c);
                    end
                    else
                        push_token(EV_CHAR, c);
                end
                default:
                    lex_between(c);
            endcase
            if (eoi)
            begin
                if (lex_mode == MODE_ATOM || lex_mode == MODE_STRING)
                    push_token(EV_END, 8'h00);
                else if (lex_mode == MODE_ESCAPE)
                    push_token(EV_ESC_ERR, 8'h00);
                lex_mode = MODE_BETWEEN;
            end
            if (expected_tokens.size() > n0)
                expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_beat(logic [7:0] ch, logic [2:0] ev, logic last);
            token_t exp_tok;
            if (expected_tokens.size() == 0)
            begin
                report($sformatf("unexpected beat event=%0d char=%02h last=%0b", ev, ch, last));
                return;
            end
            exp_tok = expected_tokens.pop_front();
            if (ev !== exp_tok.ev)
                report($sformatf("event %0d, expected %s", ev, exp_tok.ev.name()));
            if (ch !== exp_tok.ch)
                report($sformatf("char %02h, expected %02h (%s)", ch, exp_tok.ch,
                                 exp_tok.ev.name()));
            if (last !== exp_tok.last)
                report($sformatf("last %0b, expected %0b (%s)", last, exp_tok.last,
                                 exp_tok.ev.name()));
        endtask

        task drain_check();
            if (expected_tokens.size() != 0)
                report($sformatf("%0d tokens never came out", expected_tokens.size()));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] char_in
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] char_out
    logic [2:0] m_tuser;    // [2:0] event_res
    logic       m_tlast;

    token_scoreboard sb;
    text_t           src_text;
    int              sent_bytes;
    int              cycles;
    logic            tx_steady;
    logic            rx_steady;
    logic [7:0]      blank_set [0:5] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    sexpr_tokenizer_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // input noted before output: a byte may be taken in the same cycle as a beat goes out
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tuser, m_tlast);
        end
    end

    // receiver: random stall before each beat, with stall-free stretches
    initial
    begin
        int gap;
        int beats;
        beats = 0;
        rx_steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats % 32 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            gap = rx_steady ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            beats++;
            @(negedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic eoi);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= eoi;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < src_text.size(); i++)
            send_byte(src_text[i], i == src_text.size() - 1);
        sent_bytes += src_text.size();
    endtask

    function automatic void append_byte(logic [7:0] b);
        src_text = {src_text, b};
    endfunction

    function automatic logic [7:0] pick_byte(logic [7:0] not_a, logic [7:0] not_b);
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == not_a || c == not_b);
        return c;
    endfunction

    initial
    begin
        logic [7:0] c;
        sb = new();
        sent_bytes = 0;
        tx_steady = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // delimiters, quote and ';' inside an atom, escapes incl. uppercase T,
        // comment, end inside an atom
        src_text = '{CH_OPEN, 8'hFF, CH_DQUOTE, CH_SEMI, CH_CLOSE, CH_QUOTE, CH_SPACE,
                     CH_DQUOTE, CH_BSLASH, CH_LOW_N, CH_BSLASH, CH_UP_T, CH_BSLASH,
                     CH_LOW_T, CH_DQUOTE, CH_TAB, CH_SEMI, 8'h63, CH_LF, 8'h00};
        send_text();
        // end right after a backslash
        src_text = '{CH_DQUOTE, CH_BSLASH};
        send_text();
        // unterminated string
        src_text = '{CH_DQUOTE, 8'h71};
        send_text();
        // end inside a comment
        src_text = '{CH_SEMI};
        send_text();

        while (sent_bytes < RANDOM_BYTES)
        begin
            src_text.delete();
            tx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    case ($urandom_range(0, 6))
                        0: append_byte(CH_OPEN);
                        1: append_byte(CH_CLOSE);
                        2: append_byte(CH_QUOTE);
                        3: append_byte(blank_set[$urandom_range(0, 5)]);
                        4:
                        begin
                            repeat ($urandom_range(1, 5))
                            begin
                                do
                                    c = 8'($urandom);
                                while (token_scoreboard::is_blank(c) || c == CH_OPEN ||
                                       c == CH_CLOSE || c == CH_QUOTE);
                                append_byte(c);
                            end
                            if ($urandom_range(0, 1) == 0)
                                append_byte(blank_set[$urandom_range(0, 5)]);
                        end
                        5:
                        begin
                            append_byte(CH_DQUOTE);
                            repeat ($urandom_range(0, 5))
                            begin
                                if ($urandom_range(0, 3) == 0)
                                begin
                                    append_byte(CH_BSLASH);
                                    case ($urandom_range(0, 5))
                                        0: append_byte(CH_LOW_N);
                                        1: append_byte(CH_LOW_T);
                                        2: append_byte(CH_UP_T);
                                        3: append_byte(CH_DQUOTE);
                                        4: append_byte(CH_BSLASH);
                                        default: append_byte(8'($urandom));
                                    endcase
                                end
                                else
                                    append_byte(pick_byte(CH_DQUOTE, CH_BSLASH));
                            end
                            if ($urandom_range(0, 5) != 0)
                                append_byte(CH_DQUOTE);
                        end
                        default:
                        begin
                            append_byte(CH_SEMI);
                            repeat ($urandom_range(0, 4)) append_byte(pick_byte(CH_LF, CH_LF));
                            append_byte(CH_LF);
                        end
                    endcase
                end
                // string cut off right after a backslash
                if ($urandom_range(0, 7) == 0)
                begin
                    append_byte(CH_DQUOTE);
                    append_byte(CH_BSLASH);
                end
            end
            send_text();
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        sb.drain_check();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
